/* design/segment_box_collision_test_core_defines.svh */
// assertion macros for the segment box collision test core
`ifndef SEGMENT_BOX_COLLISION_TEST_CORE_DEFINES_SVH
`define SEGMENT_BOX_COLLISION_TEST_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define SBCT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sbct assertion failed");

// next-cycle implication, clocked on clk, off during rst
`define SBCT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sbct assertion failed");

`endif

/* design/sbct_pkg.sv */
package sbct_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int CLEAR_WIDTH = 13;
  localparam int EXT_WIDTH   = COORD_WIDTH + 2;
  localparam int PROD_WIDTH  = 2 * EXT_WIDTH;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = COORD_WIDTH;
  localparam int NUM_EDGES = 4;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [EXT_WIDTH-1:0]   ext_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic [CLEAR_WIDTH-1:0]        clear_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_CORNER_A_X = 3'd0,
    REG_CORNER_A_Y = 3'd1,
    REG_CORNER_B_X = 3'd2,
    REG_CORNER_B_Y = 3'd3,
    REG_CLEARANCE  = 3'd4
  } cfg_reg_t;

  localparam ext_t SAT_HI = ext_t'((2 ** (COORD_WIDTH - 1)) - 1);
  localparam ext_t SAT_LO = -SAT_HI - ext_t'(1);

  // edge test operands after the subtract stage
  typedef struct packed {
    ext_t a;
    ext_t den;
    ext_t w0;
    ext_t w1;
    ext_t du;
    logic ok;
  } edge_s2_t;

  // edge test products
  typedef struct packed {
    prod_t p0;
    prod_t p1;
    prod_t p2;
    logic  ok;
  } edge_s3_t;

  function automatic ext_t ext(input coord_t v);
    return {{(EXT_WIDTH - COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
  endfunction

  function automatic ext_t ext_clear(input clear_t c);
    return {{(EXT_WIDTH - CLEAR_WIDTH){1'b0}}, c};
  endfunction

  function automatic coord_t bound_lo(input coord_t a, input coord_t b, input clear_t c);
    ext_t m;
    ext_t r;
    m = (a < b) ? ext(a) : ext(b);
    r = m - ext_clear(c);
    if (r < SAT_LO) begin
      r = SAT_LO;
    end
    return r[COORD_WIDTH-1:0];
  endfunction

  function automatic coord_t bound_hi(input coord_t a, input coord_t b, input clear_t c);
    ext_t m;
    ext_t r;
    m = (a < b) ? ext(b) : ext(a);
    r = m + ext_clear(c);
    if (r > SAT_HI) begin
      r = SAT_HI;
    end
    return r[COORD_WIDTH-1:0];
  endfunction

  // edge at v = lv from u0 to u1, segment from p with step (du, dv)
  function automatic edge_s2_t edge_prep(input coord_t lv, input coord_t u0,
                                         input coord_t u1, input coord_t pu,
                                         input coord_t pv, input ext_t du,
                                         input ext_t dv);
    ext_t a;
    ext_t den;
    edge_s2_t r;
    if (dv > 0) begin
      a   = ext(lv) - ext(pv);
      den = dv;
    end else begin
      a   = ext(pv) - ext(lv);
      den = -dv;
    end
    r.a   = a;
    r.den = den;
    r.w0  = ext(u0) - ext(pu);
    r.w1  = ext(u1) - ext(pu);
    r.du  = du;
    r.ok  = (u1 != u0) && (dv != '0) && (a >= 0) && (a <= den);
    return r;
  endfunction

endpackage

/* design/segment_box_collision_test_core.sv */
// throughput: one segment per cycle, set by the four-stage pipeline with a
//   global advance that halts only while the output word waits
// reset: rst synchronous, clears the valid bits and sets all box registers to zero
`include "segment_box_collision_test_core_defines.svh"

module segment_box_collision_test_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [sbct_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [sbct_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // start_x, start_y, end_x, end_y
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // hit, edge_crossed, start_inside, zero fill
);

  sbct_pkg::coord_t corner_a_x;
  sbct_pkg::coord_t corner_a_y;
  sbct_pkg::coord_t corner_b_x;
  sbct_pkg::coord_t corner_b_y;
  sbct_pkg::clear_t clearance;

  logic adv;

  // stage 1: bounds and segment deltas
  logic             v1;
  sbct_pkg::coord_t xmin, xmax, ymin, ymax;
  sbct_pkg::coord_t sx, sy;
  sbct_pkg::ext_t   dx, dy;

  // stage 2: edge operands and containment
  logic               v2;
  sbct_pkg::edge_s2_t s2 [sbct_pkg::NUM_EDGES];
  logic               inside2;

  // stage 3: products
  logic               v3;
  sbct_pkg::edge_s3_t s3 [sbct_pkg::NUM_EDGES];
  logic               inside3;

  // stage 4: output word
  logic                           hit;
  logic                           edge_crossed;
  logic                           start_inside;
  logic [sbct_pkg::NUM_EDGES-1:0] meet;

  sbct_pkg::coord_t in_sx, in_sy, in_ex, in_ey;

  assign in_sx = s_tdata[15:0];
  assign in_sy = s_tdata[31:16];
  assign in_ex = s_tdata[47:32];
  assign in_ey = s_tdata[63:48];

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign m_tdata  = {5'b0, start_inside, edge_crossed, hit};

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_a_x <= '0;
      corner_a_y <= '0;
      corner_b_x <= '0;
      corner_b_y <= '0;
      clearance  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        sbct_pkg::REG_CORNER_A_X: corner_a_x <= cfg_data;
        sbct_pkg::REG_CORNER_A_Y: corner_a_y <= cfg_data;
        sbct_pkg::REG_CORNER_B_X: corner_b_x <= cfg_data;
        sbct_pkg::REG_CORNER_B_Y: corner_b_y <= cfg_data;
        sbct_pkg::REG_CLEARANCE:  clearance  <= cfg_data[sbct_pkg::CLEAR_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      v1       <= s_tvalid;
      v2       <= v1;
      v3       <= v2;
      m_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xmin <= sbct_pkg::bound_lo(corner_a_x, corner_b_x, clearance);
      xmax <= sbct_pkg::bound_hi(corner_a_x, corner_b_x, clearance);
      ymin <= sbct_pkg::bound_lo(corner_a_y, corner_b_y, clearance);
      ymax <= sbct_pkg::bound_hi(corner_a_y, corner_b_y, clearance);
      sx   <= in_sx;
      sy   <= in_sy;
      dx   <= sbct_pkg::ext(in_ex) - sbct_pkg::ext(in_sx);
      dy   <= sbct_pkg::ext(in_ey) - sbct_pkg::ext(in_sy);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2[0]   <= sbct_pkg::edge_prep(ymin, xmin, xmax, sx, sy, dx, dy);
      s2[1]   <= sbct_pkg::edge_prep(xmin, ymin, ymax, sy, sx, dy, dx);
      s2[2]   <= sbct_pkg::edge_prep(xmax, ymin, ymax, sy, sx, dy, dx);
      s2[3]   <= sbct_pkg::edge_prep(ymax, xmin, xmax, sx, sy, dx, dy);
      inside2 <= (xmin < sx) && (sx < xmax) && (ymin < sy) && (sy < ymax);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < sbct_pkg::NUM_EDGES; i++) begin
        s3[i].p0 <= s2[i].w0 * s2[i].den;
        s3[i].p1 <= s2[i].a * s2[i].du;
        s3[i].p2 <= s2[i].w1 * s2[i].den;
        s3[i].ok <= s2[i].ok;
      end
      inside3 <= inside2;
    end
  end

  always_comb begin
    for (int i = 0; i < sbct_pkg::NUM_EDGES; i++) begin
      meet[i] = s3[i].ok && (s3[i].p0 <= s3[i].p1) && (s3[i].p1 <= s3[i].p2);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      edge_crossed <= |meet;
      start_inside <= inside3;
      hit          <= (|meet) || inside3;
    end
  end

  `SBCT_ASSERT_IMP(a_hit_is_or, m_tvalid, m_tdata[0] == (m_tdata[1] || m_tdata[2]))
  `SBCT_ASSERT_IMP(a_stall_back, m_tvalid && !m_tready, !s_tready)
  `SBCT_ASSERT_NXT(a_accept_enters, s_tvalid && s_tready, v1)
  `SBCT_ASSERT_NXT(a_last_stage_moves, v3 && adv, m_tvalid)

endmodule

/* test/tb.sv */
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bit hit;
    bit crossed;
    bit contained;
  } collision_t;

  typedef logic [sbct_pkg::CFG_DATA_WIDTH-1:0] cfg_word_t;

  localparam longint COORD_HI = (longint'(1) <<< (sbct_pkg::COORD_WIDTH - 1)) - 1;
  localparam longint COORD_LO = -COORD_HI - 1;
  localparam int HOLD_AFTER = 400;
  localparam int HOLD_CYCLES = 250;
  localparam int PHASE_SEGS = 235;
  localparam int NUM_PHASES = 8;
  localparam int STEADY_PHASE = 4;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [sbct_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  cfg_word_t cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;

  logic [63:0] seg_queue[$];
  collision_t verdict_queue[$];
  sbct_pkg::coord_t box_ax = '0, box_ay = '0, box_bx = '0, box_by = '0;
  sbct_pkg::clear_t box_clear = '0;
  bit steady = 1'b0;
  int errors = 0;
  int results_seen = 0;
  int hold_left = 0;

  segment_box_collision_test_core DUT (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),   // start_x, start_y, end_x, end_y
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)    // hit, edge_crossed, start_inside, zero fill
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint clamp_coord(longint v);
    if (v > COORD_HI) return COORD_HI;
    if (v < COORD_LO) return COORD_LO;
    return v;
  endfunction

  function automatic longint grown_lo(sbct_pkg::coord_t a, sbct_pkg::coord_t b);
    longint m;
    m = (a < b) ? longint'(a) : longint'(b);
    return clamp_coord(m - longint'(box_clear));
  endfunction

  function automatic longint grown_hi(sbct_pkg::coord_t a, sbct_pkg::coord_t b);
    longint m;
    m = (a < b) ? longint'(b) : longint'(a);
    return clamp_coord(m + longint'(box_clear));
  endfunction

  // edge at v = lv running from u0 to u1, segment from (pu, pv) to (qu, qv)
  function automatic bit meets_edge(longint lv, longint u0, longint u1, longint pu,
                                    longint pv, longint qu, longint qv);
    longint du, dv, a, den;
    du = qu - pu;
    dv = qv - pv;
    if (u1 == u0 || dv == 0) return 1'b0;
    if (dv > 0) begin
      a = lv - pv;
      den = dv;
    end else begin
      a = pv - lv;
      den = -dv;
    end
    if (a < 0 || a > den) return 1'b0;
    return ((u0 - pu) * den <= a * du) && (a * du <= (u1 - pu) * den);
  endfunction

  function automatic collision_t predict_collision(logic [63:0] w);
    longint sx, sy, ex, ey, lo_x, hi_x, lo_y, hi_y;
    collision_t r;
    sx = longint'(sbct_pkg::coord_t'(w[15:0]));
    sy = longint'(sbct_pkg::coord_t'(w[31:16]));
    ex = longint'(sbct_pkg::coord_t'(w[47:32]));
    ey = longint'(sbct_pkg::coord_t'(w[63:48]));
    lo_x = grown_lo(box_ax, box_bx);
    hi_x = grown_hi(box_ax, box_bx);
    lo_y = grown_lo(box_ay, box_by);
    hi_y = grown_hi(box_ay, box_by);
    r.crossed = meets_edge(lo_y, lo_x, hi_x, sx, sy, ex, ey)
             || meets_edge(lo_x, lo_y, hi_y, sy, sx, ey, ex)
             || meets_edge(hi_x, lo_y, hi_y, sy, sx, ey, ex)
             || meets_edge(hi_y, lo_x, hi_x, sx, sy, ex, ey);
    r.contained = lo_x < sx && sx < hi_x && lo_y < sy && sy < hi_y;
    r.hit = r.crossed || r.contained;
    return r;
  endfunction

  function automatic sbct_pkg::coord_t near_coord(longint lo, longint hi);
    longint v;
    case ($urandom_range(3))
      0: v = lo + longint'($urandom_range(8)) - 4;
      1: v = hi + longint'($urandom_range(8)) - 4;
      2: v = lo + longint'($urandom_range(int'(hi - lo)));
      default: v = longint'(sbct_pkg::coord_t'($urandom));
    endcase
    return sbct_pkg::coord_t'(clamp_coord(v));
  endfunction

  task automatic push_seg(sbct_pkg::coord_t sx, sbct_pkg::coord_t sy,
                          sbct_pkg::coord_t ex, sbct_pkg::coord_t ey);
    seg_queue.push_back({ey, ex, sy, sx});
  endtask

  task automatic write_reg(sbct_pkg::cfg_reg_t idx, cfg_word_t val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      sbct_pkg::REG_CORNER_A_X: box_ax = sbct_pkg::coord_t'(val);
      sbct_pkg::REG_CORNER_A_Y: box_ay = sbct_pkg::coord_t'(val);
      sbct_pkg::REG_CORNER_B_X: box_bx = sbct_pkg::coord_t'(val);
      sbct_pkg::REG_CORNER_B_Y: box_by = sbct_pkg::coord_t'(val);
      sbct_pkg::REG_CLEARANCE:  box_clear = sbct_pkg::clear_t'(val);
      default: ;
    endcase
  endtask

  task automatic set_box(sbct_pkg::coord_t ax, sbct_pkg::coord_t ay, sbct_pkg::coord_t bx,
                         sbct_pkg::coord_t by, sbct_pkg::clear_t c);
    write_reg(sbct_pkg::REG_CORNER_A_X, ax);
    write_reg(sbct_pkg::REG_CORNER_A_Y, ay);
    write_reg(sbct_pkg::REG_CORNER_B_X, bx);
    write_reg(sbct_pkg::REG_CORNER_B_Y, by);
    write_reg(sbct_pkg::REG_CLEARANCE, cfg_word_t'(c));
  endtask

  task automatic wait_drained();
    while (seg_queue.size() != 0 || s_tvalid || verdict_queue.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        verdict_queue.push_back(predict_collision(s_tdata));
      if (!s_tvalid || s_tready) begin
        if (seg_queue.size() != 0 && (steady || $urandom_range(99) >= 33)) begin
          s_tdata <= seg_queue.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    collision_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (results_seen == HOLD_AFTER)
          hold_left = HOLD_CYCLES;
        if (verdict_queue.size() == 0) begin
          $display("%t: result word expected none, actual %b", $time, m_tdata);
          errors++;
        end else begin
          want = verdict_queue.pop_front();
          if (m_tdata[0] !== want.hit || m_tdata[1] !== want.crossed
              || m_tdata[2] !== want.contained) begin
            $display("%t: hit/edge/inside expected %b%b%b actual %b%b%b", $time,
                     want.hit, want.crossed, want.contained,
                     m_tdata[0], m_tdata[1], m_tdata[2]);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= steady || ($urandom_range(99) >= 33);
      end
    end
  end

  initial begin
    #500us;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    sbct_pkg::coord_t ax, ay, bx, by, sx, sy, ex, ey;
    sbct_pkg::clear_t c;
    longint lo_x, hi_x, lo_y, hi_y;
    int r;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // corners given in reverse order, grown box is x -176..336, y -96..256
    set_box(16'sd320, 16'sd240, -16'sd160, -16'sd80, 13'd16);
    push_seg(-16'sd1000, 16'sd0, 16'sd1000, 16'sd0);
    push_seg(16'sd0, -16'sd1000, 16'sd0, 16'sd1000);
    push_seg(16'sd0, 16'sd0, 16'sd10, 16'sd10);
    push_seg(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    push_seg(16'sd0, 16'sd0, 16'sd1000, 16'sd0);
    push_seg(-16'sd1000, 16'sd10, 16'sd0, 16'sd10);
    push_seg(-16'sd176, 16'sd0, -16'sd176, 16'sd0);
    push_seg(-16'sd176, 16'sd0, -16'sd176, 16'sd100);
    push_seg(-16'sd500, 16'sd0, -16'sd176, 16'sd0);
    push_seg(-16'sd500, 16'sd0, -16'sd177, 16'sd0);
    push_seg(-16'sd500, -16'sd96, 16'sd500, -16'sd96);
    push_seg(-16'sd176, -16'sd96, -16'sd1000, -16'sd1000);
    push_seg(16'sd1000, 16'sd1000, 16'sd2000, 16'sd2000);
    push_seg(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
    push_seg(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768);
    push_seg(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
    push_seg(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    push_seg(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    push_seg(-16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767);
    push_seg(16'sd336, 16'sd256, 16'sd336, 16'sd256);
    push_seg(16'sd335, 16'sd255, 16'sd335, 16'sd255);
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 7)
        0: begin
          ax = sbct_pkg::coord_t'($urandom_range(4000)) - 16'sd2000;
          ay = sbct_pkg::coord_t'($urandom_range(4000)) - 16'sd2000;
          bx = sbct_pkg::coord_t'($urandom_range(4000)) - 16'sd2000;
          by = sbct_pkg::coord_t'($urandom_range(4000)) - 16'sd2000;
          c = sbct_pkg::clear_t'($urandom_range(200));
        end
        1: begin
          ax = -16'sd32768; ay = -16'sd32768; bx = 16'sd32767; by = 16'sd32767;
          c = 13'd8191;
        end
        2: begin
          ax = sbct_pkg::coord_t'($urandom); ay = sbct_pkg::coord_t'($urandom);
          bx = ax; by = ay; c = '0;
        end
        3: begin
          ax = sbct_pkg::coord_t'($urandom); ay = sbct_pkg::coord_t'($urandom);
          bx = ax; by = ay; c = sbct_pkg::clear_t'($urandom);
        end
        4: begin
          ax = 16'sd32767; ay = 16'sd32767; bx = -16'sd32768; by = -16'sd32768;
          c = '0;
        end
        5: begin
          ax = sbct_pkg::coord_t'($urandom); ay = sbct_pkg::coord_t'($urandom);
          bx = sbct_pkg::coord_t'($urandom); by = sbct_pkg::coord_t'($urandom);
          c = sbct_pkg::clear_t'($urandom);
        end
        default: begin
          ax = sbct_pkg::coord_t'($urandom_range(2000));
          ay = sbct_pkg::coord_t'($urandom_range(2000));
          bx = ax; by = -ay; c = '0;
        end
      endcase
      if (ph == NUM_PHASES - 1) begin
        ax = 16'sd32767; ay = -16'sd32768; bx = 16'sd100; by = 16'sd100;
        c = 13'd8191;
      end
      set_box(ax, ay, bx, by, c);
      @(posedge clk);
      steady <= (ph == STEADY_PHASE);
      lo_x = grown_lo(box_ax, box_bx);
      hi_x = grown_hi(box_ax, box_bx);
      lo_y = grown_lo(box_ay, box_by);
      hi_y = grown_hi(box_ay, box_by);
      for (int i = 0; i < PHASE_SEGS; i++) begin
        r = $urandom_range(99);
        if (r < 35) begin
          sx = sbct_pkg::coord_t'($urandom); sy = sbct_pkg::coord_t'($urandom);
          ex = sbct_pkg::coord_t'($urandom); ey = sbct_pkg::coord_t'($urandom);
        end else begin
          sx = near_coord(lo_x, hi_x);
          sy = near_coord(lo_y, hi_y);
          ex = near_coord(lo_x, hi_x);
          ey = near_coord(lo_y, hi_y);
          if (r >= 90) begin
            ex = sx;
            ey = sy;
          end else if (r >= 80) begin
            if ($urandom_range(1)) ex = sx;
            else ey = sy;
          end
        end
        push_seg(sx, sy, ex, ey);
      end
      wait_drained();
      @(posedge clk);
      steady <= 1'b0;
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0 && verdict_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
